/* rtl/rrc_pkg.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rrc_pkg
// Shared types, constants and the CORDIC angle table for the cylinder wrap unit.
// -----------------------------------------------------------------------------
package rrc_pkg;

   localparam int DATA_W           = 32;
   localparam int PROD_W           = 64;
   localparam int RADIUS_W         = 30;
   localparam int ADDR_W           = 3;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 30;

   // CORDIC start magnitude, Q1.30
   localparam logic signed [DATA_W-1:0] CORDIC_GAIN = 32'sd652032874;
   // 2^32 / (2*pi)
   localparam logic [RADIUS_W-1:0] INV_TWO_PI = 30'd683565276;

   // register index (byte address bit 2)
   localparam logic REG_WRAP_X = 1'b0;
   localparam logic REG_WRAP_Y = 1'b1;

   // quadrant codes (top two bits of the phase)
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
   } req_item_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_x;
      logic signed [DATA_W-1:0] out_y;
      logic signed [DATA_W-1:0] out_z;
      logic                     zero_wrap_flag;
   } rsp_item_type;

   // dot products carried through the square root
   typedef struct packed {
      logic [PROD_W-1:0] mag_x;
      logic              neg_x;
      logic [PROD_W-1:0] mag_y;
      logic              neg_y;
   } dot_type;

   // riders on the x' divider
   typedef struct packed {
      logic                neg;
      logic                ovf;
      logic                zero;
      logic [RADIUS_W-1:0] radius;
   } xside_type;

   // riders on the y' divider
   typedef struct packed {
      logic neg;
      logic ovf;
   } yside_type;

   // riders on the phase dividers
   typedef struct packed {
      logic                     neg_x;
      logic signed [DATA_W-1:0] rot_y;
      logic                     zero;
      logic [RADIUS_W-1:0]      radius;
   } pside_type;

   // riders on the CORDIC stages
   typedef struct packed {
      logic [1:0]               quad;
      logic signed [DATA_W-1:0] rot_y;
      logic                     zero;
      logic [RADIUS_W-1:0]      radius;
   } cside_type;

   // arctangent of 2^-i in 2^-32 turn units
   function automatic logic [DATA_W-1:0] atan_turn(input int idx);
      logic [DATA_W-1:0] v;
      case (idx)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2FA;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         24: v = 32'h00000029;
         25: v = 32'h00000014;
         26: v = 32'h0000000A;
         27: v = 32'h00000005;
         28: v = 32'h00000003;
         29: v = 32'h00000001;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* rtl/rrc_divider.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rrc_divider
// Pipelined restoring divider, one quotient bit per stage. The partial
// remainder may start nonzero (it must be below the divisor), which lets a
// wide dividend be split into a high remainder word and a low word.
// -----------------------------------------------------------------------------
module rrc_divider #(
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [rrc_pkg::DATA_W-1:0] in_rem,
   input  logic [rrc_pkg::DATA_W-1:0] in_num,
   input  logic [rrc_pkg::DATA_W-1:0] in_den,
   input  logic [SIDE_W-1:0]          in_side,
   output logic                      out_valid,
   output logic [rrc_pkg::DATA_W-1:0] out_quo,
   output logic [rrc_pkg::DATA_W-1:0] out_rem,
   output logic [rrc_pkg::DATA_W-1:0] out_den,
   output logic [SIDE_W-1:0]          out_side
);
   import rrc_pkg::*;

   localparam int STEPS = DATA_W;

   logic              valid_ff [STEPS];
   logic [DATA_W-1:0] rem_ff   [STEPS];
   logic [DATA_W-1:0] num_ff   [STEPS];
   logic [DATA_W-1:0] den_ff   [STEPS];
   logic [SIDE_W-1:0] side_ff  [STEPS];

   logic              valid_src [STEPS];
   logic [DATA_W-1:0] rem_src   [STEPS];
   logic [DATA_W-1:0] num_src   [STEPS];
   logic [DATA_W-1:0] den_src   [STEPS];
   logic [SIDE_W-1:0] side_src  [STEPS];

   genvar k;
   generate
      for (k = 0; k < STEPS; k++) begin : g_step
         logic [DATA_W:0] trial;
         logic [DATA_W:0] diff;
         logic            take;

         if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign rem_src[k]   = in_rem;
            assign num_src[k]   = in_num;
            assign den_src[k]   = in_den;
            assign side_src[k]  = in_side;
         end else begin : g_next
            assign valid_src[k] = valid_ff[k-1];
            assign rem_src[k]   = rem_ff[k-1];
            assign num_src[k]   = num_ff[k-1];
            assign den_src[k]   = den_ff[k-1];
            assign side_src[k]  = side_ff[k-1];
         end

         // shift in the next dividend bit and try the subtract
         assign trial = {rem_src[k], num_src[k][DATA_W-1]};
         assign diff  = trial - {1'b0, den_src[k]};
         assign take  = (trial >= {1'b0, den_src[k]});

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= valid_src[k];
            end
         end

         // quotient bits enter at the bottom as dividend bits leave the top
         always_ff @(posedge clock) begin
            rem_ff[k]  <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            num_ff[k]  <= {num_src[k][DATA_W-2:0], take};
            den_ff[k]  <= den_src[k];
            side_ff[k] <= side_src[k];
         end
      end
   endgenerate

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = num_ff[STEPS-1];
   assign out_rem   = rem_ff[STEPS-1];
   assign out_den   = den_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

/* rtl/rotate_and_roll_onto_cylinder_unit.sv */
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rotate_and_roll_onto_cylinder_unit
// Rotates a Q16.16 point so the wrapping vector lies on x, then rolls it onto
// a cylinder of circumference |W| (square root, four divides, CORDIC).
//
// Usage:
//  - Input: drive req_item and raise start; a beat is taken when start is
//    high and busy is low. busy is high only during reset.
//  - Output: one result per beat, shown for one cycle with rsp_valid.
//    The receiver cannot stall, so no result is ever held back.
//  - Pipeline: 32 square root stages, four 32-stage dividers (x' and y'
//    side by side, then the two phase divides), one stage per CORDIC step
//    and ten stages of products, saturation and rounding.
//  - Throughput is one beat per cycle; every stage is a register.
//  - wrap_vec_x at byte address 0, wrap_vec_y at 4, through the APB port.
//    Write them only while no beat is in flight; each beat picks up the
//    values on the cycle it is taken.
//  - Reset clears all valid bits and sets the wrapping vector to (1.0, 0).
// -----------------------------------------------------------------------------
module rotate_and_roll_onto_cylinder_unit #(
   parameter int CORDIC_STEPS = rrc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  rrc_pkg::req_item_type      req_item,
   output logic                       rsp_valid,
   output rrc_pkg::rsp_item_type      rsp_item,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [rrc_pkg::ADDR_W-1:0] paddr,
   input  logic [rrc_pkg::DATA_W-1:0] pwdata,
   output logic [rrc_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import rrc_pkg::*;

   localparam int ROOT_STEPS = DATA_W;
   localparam int LATENCY    = 138 + CORDIC_STEPS;

   // ---------------------------------------------------------------- config
   logic [DATA_W-1:0] wrap_x_ff;
   logic [DATA_W-1:0] wrap_y_ff;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_x_ff <= 32'h0001_0000;
         wrap_y_ff <= '0;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_WRAP_X: wrap_x_ff <= pwdata;
            REG_WRAP_Y: wrap_y_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WRAP_X: prdata = wrap_x_ff;
         REG_WRAP_Y: prdata = wrap_y_ff;
         default:    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- accept
   logic accept;

   assign busy   = reset;
   assign accept = start && !busy;

   logic              s0_valid_ff;
   logic [DATA_W-1:0] s0_px_ff, s0_py_ff, s0_wx_ff, s0_wy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      s0_px_ff <= req_item.pos_x;
      s0_py_ff <= req_item.pos_y;
      s0_wx_ff <= wrap_x_ff;
      s0_wy_ff <= wrap_y_ff;
   end

   // ---------------------------------------------------------------- magnitudes
   logic              a_valid_ff;
   logic [DATA_W-1:0] a_mwx_ff, a_mwy_ff, a_mpx_ff, a_mpy_ff;
   logic              a_swx_ff, a_swy_ff, a_spx_ff, a_spy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_mwx_ff <= s0_wx_ff[DATA_W-1] ? (~s0_wx_ff + 1'b1) : s0_wx_ff;
      a_mwy_ff <= s0_wy_ff[DATA_W-1] ? (~s0_wy_ff + 1'b1) : s0_wy_ff;
      a_mpx_ff <= s0_px_ff[DATA_W-1] ? (~s0_px_ff + 1'b1) : s0_px_ff;
      a_mpy_ff <= s0_py_ff[DATA_W-1] ? (~s0_py_ff + 1'b1) : s0_py_ff;
      a_swx_ff <= s0_wx_ff[DATA_W-1];
      a_swy_ff <= s0_wy_ff[DATA_W-1];
      a_spx_ff <= s0_px_ff[DATA_W-1];
      a_spy_ff <= s0_py_ff[DATA_W-1];
   end

   // ---------------------------------------------------------------- products
   logic              b_valid_ff;
   logic [PROD_W-1:0] b_sqx_ff, b_sqy_ff, b_xx_ff, b_yy_ff, b_xy_ff, b_yx_ff;
   logic              b_n1x_ff, b_n2x_ff, b_n1y_ff, b_n2y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_sqx_ff <= a_mwx_ff * a_mwx_ff;
      b_sqy_ff <= a_mwy_ff * a_mwy_ff;
      b_xx_ff  <= a_mwx_ff * a_mpx_ff;
      b_yy_ff  <= a_mwy_ff * a_mpy_ff;
      b_xy_ff  <= a_mwx_ff * a_mpy_ff;
      b_yx_ff  <= a_mwy_ff * a_mpx_ff;
      b_n1x_ff <= a_swx_ff ^ a_spx_ff;
      b_n2x_ff <= a_swy_ff ^ a_spy_ff;
      b_n1y_ff <= a_swx_ff ^ a_spy_ff;
      b_n2y_ff <= !(a_swy_ff ^ a_spx_ff);
   end

   // ---------------------------------------------------------------- signed sums
   function automatic logic [PROD_W:0] dot_combine(input logic n1, input logic [PROD_W-1:0] m1,
                                                   input logic n2, input logic [PROD_W-1:0] m2);
      logic [PROD_W:0] res;
      if (n1 == n2) begin
         res = {n1, m1 + m2};
      end else if (m1 >= m2) begin
         res = {n1, m1 - m2};
      end else begin
         res = {n2, m2 - m1};
      end
      return res;
   endfunction

   logic              c_valid_ff;
   logic [PROD_W-1:0] c_rad_ff;
   dot_type           c_dot_ff;
   logic [PROD_W:0]   c_sum_x, c_sum_y;

   assign c_sum_x = dot_combine(b_n1x_ff, b_xx_ff, b_n2x_ff, b_yy_ff);
   assign c_sum_y = dot_combine(b_n1y_ff, b_xy_ff, b_n2y_ff, b_yx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_rad_ff       <= b_sqx_ff + b_sqy_ff;
      c_dot_ff.neg_x <= c_sum_x[PROD_W];
      c_dot_ff.mag_x <= c_sum_x[PROD_W-1:0];
      c_dot_ff.neg_y <= c_sum_y[PROD_W];
      c_dot_ff.mag_y <= c_sum_y[PROD_W-1:0];
   end

   // ---------------------------------------------------------------- square root
   // one root bit per stage, two radicand bits shifted in each time
   logic              rt_valid_ff [ROOT_STEPS];
   logic [PROD_W-1:0] rt_rad_ff   [ROOT_STEPS];
   logic [DATA_W+1:0] rt_rem_ff   [ROOT_STEPS];
   logic [DATA_W-1:0] rt_root_ff  [ROOT_STEPS];
   dot_type           rt_dot_ff   [ROOT_STEPS];

   logic              rt_valid_src [ROOT_STEPS];
   logic [PROD_W-1:0] rt_rad_src   [ROOT_STEPS];
   logic [DATA_W+1:0] rt_rem_src   [ROOT_STEPS];
   logic [DATA_W-1:0] rt_root_src  [ROOT_STEPS];
   dot_type           rt_dot_src   [ROOT_STEPS];

   genvar k;
   generate
      for (k = 0; k < ROOT_STEPS; k++) begin : g_root
         logic [DATA_W+1:0] cand;
         logic [DATA_W+1:0] trial;
         logic              take;

         if (k == 0) begin : g_first
            assign rt_valid_src[k] = c_valid_ff;
            assign rt_rad_src[k]   = c_rad_ff;
            assign rt_rem_src[k]   = '0;
            assign rt_root_src[k]  = '0;
            assign rt_dot_src[k]   = c_dot_ff;
         end else begin : g_next
            assign rt_valid_src[k] = rt_valid_ff[k-1];
            assign rt_rad_src[k]   = rt_rad_ff[k-1];
            assign rt_rem_src[k]   = rt_rem_ff[k-1];
            assign rt_root_src[k]  = rt_root_ff[k-1];
            assign rt_dot_src[k]   = rt_dot_ff[k-1];
         end

         assign cand  = {rt_rem_src[k][DATA_W-1:0], rt_rad_src[k][PROD_W-1 -: 2]};
         assign trial = {rt_root_src[k], 2'b01};
         assign take  = (cand >= trial);

         always_ff @(posedge clock) begin
            if (reset) begin
               rt_valid_ff[k] <= 1'b0;
            end else begin
               rt_valid_ff[k] <= rt_valid_src[k];
            end
         end

         always_ff @(posedge clock) begin
            rt_rad_ff[k]  <= {rt_rad_src[k][PROD_W-3:0], 2'b00};
            rt_rem_ff[k]  <= take ? (cand - trial) : cand;
            rt_root_ff[k] <= {rt_root_src[k][DATA_W-2:0], take};
            rt_dot_ff[k]  <= rt_dot_src[k];
         end
      end
   endgenerate

   // ---------------------------------------------------------------- divide setup
   logic                    pr_valid_ff;
   logic [DATA_W-1:0]       pr_len_ff;
   dot_type                 pr_dot_ff;
   xside_type               pr_xside_ff;
   yside_type               pr_yside_ff;
   logic [DATA_W-1:0]       pr_len;
   dot_type                 pr_dot;
   logic [PROD_W-1:0]       pr_scaled;

   assign pr_len    = rt_root_ff[ROOT_STEPS-1];
   assign pr_dot    = rt_dot_ff[ROOT_STEPS-1];
   assign pr_scaled = pr_len * INV_TWO_PI + 64'h8000_0000;

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else begin
         pr_valid_ff <= rt_valid_ff[ROOT_STEPS-1];
      end
   end

   // quotient of 2^32 or more saturates; catch it before the 32-bit divide
   always_ff @(posedge clock) begin
      pr_len_ff          <= pr_len;
      pr_dot_ff          <= pr_dot;
      pr_xside_ff.neg    <= pr_dot.neg_x;
      pr_xside_ff.ovf    <= (pr_dot.mag_x[PROD_W-1:DATA_W] >= pr_len);
      pr_xside_ff.zero   <= (pr_len == '0);
      pr_xside_ff.radius <= pr_scaled[DATA_W +: RADIUS_W];
      pr_yside_ff.neg    <= pr_dot.neg_y;
      pr_yside_ff.ovf    <= (pr_dot.mag_y[PROD_W-1:DATA_W] >= pr_len);
   end

   // ---------------------------------------------------------------- rotation divides
   logic              dx_valid;
   logic [DATA_W-1:0] dx_quo, dx_den;
   xside_type         dx_side;
   logic [DATA_W-1:0] dy_quo;
   yside_type         dy_side;

   rrc_divider #(.SIDE_W($bits(xside_type))) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pr_valid_ff),
      .in_rem   (pr_dot_ff.mag_x[PROD_W-1:DATA_W]),
      .in_num   (pr_dot_ff.mag_x[DATA_W-1:0]),
      .in_den   (pr_len_ff),
      .in_side  (pr_xside_ff),
      .out_valid(dx_valid),
      .out_quo  (dx_quo),
      .out_rem  (),
      .out_den  (dx_den),
      .out_side (dx_side)
   );

   rrc_divider #(.SIDE_W($bits(yside_type))) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pr_valid_ff),
      .in_rem   (pr_dot_ff.mag_y[PROD_W-1:DATA_W]),
      .in_num   (pr_dot_ff.mag_y[DATA_W-1:0]),
      .in_den   (pr_len_ff),
      .in_side  (pr_yside_ff),
      .out_valid(),
      .out_quo  (dy_quo),
      .out_rem  (),
      .out_den  (),
      .out_side (dy_side)
   );

   // ---------------------------------------------------------------- saturate
   localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;
   localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;

   logic              st_valid_ff;
   logic [DATA_W-1:0] st_ax_ff;
   logic [DATA_W-1:0] st_len_ff;
   pside_type         st_side_ff;
   logic [DATA_W-1:0] st_ax, st_ay;

   always_comb begin
      if (dx_side.neg) begin
         st_ax = (dx_side.ovf || (dx_quo > NEG_LIMIT)) ? NEG_LIMIT : dx_quo;
      end else begin
         st_ax = (dx_side.ovf || dx_quo[DATA_W-1]) ? POS_LIMIT : dx_quo;
      end
      if (dy_side.neg) begin
         st_ay = (dy_side.ovf || (dy_quo > NEG_LIMIT)) ? NEG_LIMIT : dy_quo;
      end else begin
         st_ay = (dy_side.ovf || dy_quo[DATA_W-1]) ? POS_LIMIT : dy_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= dx_valid;
      end
   end

   always_ff @(posedge clock) begin
      st_ax_ff          <= st_ax;
      st_len_ff         <= dx_den;
      st_side_ff.neg_x  <= dx_side.neg;
      st_side_ff.rot_y  <= dy_side.neg ? (~st_ay + 1'b1) : st_ay;
      st_side_ff.zero   <= dx_side.zero;
      st_side_ff.radius <= dx_side.radius;
   end

   // ---------------------------------------------------------------- phase divides
   // |x'| mod L first, then that remainder times 2^32 over L gives the
   // fractional turns (the integer turns drop out mod 2^32)
   logic              md_valid;
   logic [DATA_W-1:0] md_rem, md_den;
   pside_type         md_side;
   logic              fr_valid;
   logic [DATA_W-1:0] fr_quo;
   pside_type         fr_side;

   rrc_divider #(.SIDE_W($bits(pside_type))) u_div_mod (
      .clock    (clock),
      .reset    (reset),
      .in_valid (st_valid_ff),
      .in_rem   ('0),
      .in_num   (st_ax_ff),
      .in_den   (st_len_ff),
      .in_side  (st_side_ff),
      .out_valid(md_valid),
      .out_quo  (),
      .out_rem  (md_rem),
      .out_den  (md_den),
      .out_side (md_side)
   );

   rrc_divider #(.SIDE_W($bits(pside_type))) u_div_frac (
      .clock    (clock),
      .reset    (reset),
      .in_valid (md_valid),
      .in_rem   (md_rem),
      .in_num   ('0),
      .in_den   (md_den),
      .in_side  (md_side),
      .out_valid(fr_valid),
      .out_quo  (fr_quo),
      .out_rem  (),
      .out_den  (),
      .out_side (fr_side)
   );

   // ---------------------------------------------------------------- phase
   logic                     ph_valid_ff;
   logic signed [DATA_W-1:0] ph_z_ff;
   cside_type                ph_side_ff;
   logic [DATA_W-1:0]        ph_phase;

   assign ph_phase = fr_side.neg_x ? (~fr_quo + 1'b1) : fr_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_valid_ff <= 1'b0;
      end else begin
         ph_valid_ff <= fr_valid;
      end
   end

   always_ff @(posedge clock) begin
      ph_z_ff           <= {2'b00, ph_phase[DATA_W-3:0]};
      ph_side_ff.quad   <= ph_phase[DATA_W-1 -: 2];
      ph_side_ff.rot_y  <= fr_side.rot_y;
      ph_side_ff.zero   <= fr_side.zero;
      ph_side_ff.radius <= fr_side.radius;
   end

   // ---------------------------------------------------------------- CORDIC
   logic                     cd_valid_ff [CORDIC_STEPS];
   logic signed [DATA_W-1:0] cd_x_ff     [CORDIC_STEPS];
   logic signed [DATA_W-1:0] cd_y_ff     [CORDIC_STEPS];
   logic signed [DATA_W-1:0] cd_z_ff     [CORDIC_STEPS];
   cside_type                cd_side_ff  [CORDIC_STEPS];

   logic                     cd_valid_src [CORDIC_STEPS];
   logic signed [DATA_W-1:0] cd_x_src     [CORDIC_STEPS];
   logic signed [DATA_W-1:0] cd_y_src     [CORDIC_STEPS];
   logic signed [DATA_W-1:0] cd_z_src     [CORDIC_STEPS];
   cside_type                cd_side_src  [CORDIC_STEPS];

   generate
      for (k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
         logic signed [DATA_W-1:0] dx;
         logic signed [DATA_W-1:0] dy;
         logic signed [DATA_W-1:0] ang;

         if (k == 0) begin : g_first
            assign cd_valid_src[k] = ph_valid_ff;
            assign cd_x_src[k]     = CORDIC_GAIN;
            assign cd_y_src[k]     = '0;
            assign cd_z_src[k]     = ph_z_ff;
            assign cd_side_src[k]  = ph_side_ff;
         end else begin : g_next
            assign cd_valid_src[k] = cd_valid_ff[k-1];
            assign cd_x_src[k]     = cd_x_ff[k-1];
            assign cd_y_src[k]     = cd_y_ff[k-1];
            assign cd_z_src[k]     = cd_z_ff[k-1];
            assign cd_side_src[k]  = cd_side_ff[k-1];
         end

         assign dx  = cd_y_src[k] >>> k;
         assign dy  = cd_x_src[k] >>> k;
         assign ang = $signed(atan_turn(k));

         always_ff @(posedge clock) begin
            if (reset) begin
               cd_valid_ff[k] <= 1'b0;
            end else begin
               cd_valid_ff[k] <= cd_valid_src[k];
            end
         end

         // rotate toward zero residual angle
         always_ff @(posedge clock) begin
            if (!cd_z_src[k][DATA_W-1]) begin
               cd_x_ff[k] <= cd_x_src[k] - dx;
               cd_y_ff[k] <= cd_y_src[k] + dy;
               cd_z_ff[k] <= cd_z_src[k] - ang;
            end else begin
               cd_x_ff[k] <= cd_x_src[k] + dx;
               cd_y_ff[k] <= cd_y_src[k] - dy;
               cd_z_ff[k] <= cd_z_src[k] + ang;
            end
            cd_side_ff[k] <= cd_side_src[k];
         end
      end
   endgenerate

   // ---------------------------------------------------------------- quadrant
   logic                     qd_valid_ff;
   logic signed [DATA_W-1:0] qd_cos_ff, qd_sin_ff;
   cside_type                qd_side_ff;
   logic signed [DATA_W-1:0] qd_x, qd_y;
   cside_type                qd_side;

   assign qd_x    = cd_x_ff[CORDIC_STEPS-1];
   assign qd_y    = cd_y_ff[CORDIC_STEPS-1];
   assign qd_side = cd_side_ff[CORDIC_STEPS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         qd_valid_ff <= 1'b0;
      end else begin
         qd_valid_ff <= cd_valid_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      case (qd_side.quad)
         QUAD_FIRST: begin
            qd_cos_ff <= qd_x;
            qd_sin_ff <= qd_y;
         end
         QUAD_SECOND: begin
            qd_cos_ff <= -qd_y;
            qd_sin_ff <= qd_x;
         end
         QUAD_THIRD: begin
            qd_cos_ff <= -qd_x;
            qd_sin_ff <= -qd_y;
         end
         default: begin
            qd_cos_ff <= qd_y;
            qd_sin_ff <= -qd_x;
         end
      endcase
      qd_side_ff <= qd_side;
   end

   // ---------------------------------------------------------------- scale by radius
   logic                     mu_valid_ff;
   logic signed [PROD_W-1:0] mu_sin_ff, mu_cos_ff;
   logic signed [DATA_W-1:0] mu_rot_y_ff;
   logic                     mu_zero_ff;
   logic signed [DATA_W-1:0] mu_radius;

   assign mu_radius = $signed({{(DATA_W-RADIUS_W){1'b0}}, qd_side_ff.radius});

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_valid_ff <= 1'b0;
      end else begin
         mu_valid_ff <= qd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mu_sin_ff   <= mu_radius * qd_sin_ff;
      mu_cos_ff   <= mu_radius * qd_cos_ff;
      mu_rot_y_ff <= qd_side_ff.rot_y;
      mu_zero_ff  <= qd_side_ff.zero;
   end

   // ---------------------------------------------------------------- round and output
   localparam logic signed [PROD_W-1:0] ROUND_HALF = 64'sd536870912;

   logic              rsp_valid_ff;
   rsp_item_type      rsp_item_ff;
   logic [PROD_W-1:0] rn_sin, rn_cos;

   assign rn_sin = mu_sin_ff + ROUND_HALF;
   assign rn_cos = mu_cos_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= mu_valid_ff;
      end
   end

   // zero-length wrap vector forces zero outputs
   always_ff @(posedge clock) begin
      if (mu_zero_ff) begin
         rsp_item_ff.out_x <= '0;
         rsp_item_ff.out_y <= '0;
         rsp_item_ff.out_z <= '0;
      end else begin
         rsp_item_ff.out_x <= rn_sin[30 +: DATA_W];
         rsp_item_ff.out_y <= mu_rot_y_ff;
         rsp_item_ff.out_z <= rn_cos[30 +: DATA_W];
      end
      rsp_item_ff.zero_wrap_flag <= mu_zero_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // ---------------------------------------------------------------- assertions
   a_latency : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result beat without an accepted beat at fixed latency");

   a_zero_out : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.zero_wrap_flag |->
         rsp_item.out_x == '0 && rsp_item.out_y == '0 && rsp_item.out_z == '0)
      else $error("zero wrap vector with nonzero outputs");

   a_no_busy : assert property (@(posedge clock)
      !reset |-> !busy)
      else $error("busy raised outside reset");

endmodule
